### rtl/ft12_pkg.sv
// Shared types, codes and constants for the FT1.2 frame parser.
package ft12_pkg;

    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 3;
    localparam int ERR_W          = 3;
    localparam int CFG_INDEX_W    = 3;
    localparam int FIXED_BODY_LEN = 6;
    localparam int MIN_VAR_LEN    = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIXED_START    = 3'd0,
        REG_VARIABLE_START = 3'd1,
        REG_FIXED_STOP     = 3'd2,
        REG_VARIABLE_STOP  = 3'd3,
        REG_ACK_CHAR       = 3'd4,
        REG_ERROR_CHAR     = 3'd5
    } cfg_reg_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA      = 3'd0,
        KIND_DONE      = 3'd1,
        KIND_ACK       = 3'd2,
        KIND_ERR_CHAR  = 3'd3,
        KIND_FRAME_ERR = 3'd4
    } kind_t;

    // Frame error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE         = 3'd0,
        ERR_NO_START     = 3'd1,
        ERR_LEN_MISMATCH = 3'd2,
        ERR_BAD_RSTART   = 3'd3,
        ERR_NO_STOP      = 3'd4,
        ERR_TOO_SHORT    = 3'd5
    } err_code_t;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_LEN1   = 4'd1,
        PH_LEN2   = 4'd2,
        PH_RSTART = 4'd3,
        PH_CTRL   = 4'd4,
        PH_ADDR   = 4'd5,
        PH_CMD    = 4'd6,
        PH_DATA   = 4'd7,
        PH_SUM    = 4'd8,
        PH_STOP   = 4'd9
    } phase_t;

    // One classified byte as it travels from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              is_ack;
        logic              is_err;
        logic              is_fstart;
        logic              is_vstart;
        logic              is_fstop;
        logic              is_vstop;
    } item_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_stat_t;

    // One result item
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_value;
        logic [BYTE_W-1:0] ctrl_value;
        logic [BYTE_W-1:0] address_value;
        logic [BYTE_W-1:0] command_value;
        logic [BYTE_W-1:0] data_count;
        logic              checksum_ok;
        err_code_t         error_code;
        logic              last;
    } result_t;

endpackage

### rtl/ft12_front.sv
// Front end: configuration registers, input transfer and byte classification.
module ft12_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ft12_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ft12_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ft12_pkg::BYTE_W-1:0]         s_rx_value,
    input  ft12_pkg::queue_stat_t               q_stat,
    output logic                                push,
    output ft12_pkg::item_t                     push_item
);

    logic [ft12_pkg::BYTE_W-1:0] fixed_start_reg;
    logic [ft12_pkg::BYTE_W-1:0] variable_start_reg;
    logic [ft12_pkg::BYTE_W-1:0] fixed_stop_reg;
    logic [ft12_pkg::BYTE_W-1:0] variable_stop_reg;
    logic [ft12_pkg::BYTE_W-1:0] ack_char_reg;
    logic [ft12_pkg::BYTE_W-1:0] error_char_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_start_reg    <= 8'd16;
            variable_start_reg <= 8'd104;
            fixed_stop_reg     <= 8'd22;
            variable_stop_reg  <= 8'd22;
            ack_char_reg       <= 8'd229;
            error_char_reg     <= 8'd162;
        end else if (cfg_wr_en) begin
            case (ft12_pkg::cfg_reg_t'(cfg_index))
                ft12_pkg::REG_FIXED_START:    fixed_start_reg    <= cfg_wdata;
                ft12_pkg::REG_VARIABLE_START: variable_start_reg <= cfg_wdata;
                ft12_pkg::REG_FIXED_STOP:     fixed_stop_reg     <= cfg_wdata;
                ft12_pkg::REG_VARIABLE_STOP:  variable_stop_reg  <= cfg_wdata;
                ft12_pkg::REG_ACK_CHAR:       ack_char_reg       <= cfg_wdata;
                ft12_pkg::REG_ERROR_CHAR:     error_char_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept whenever the queue has room
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // Compare the byte against every character of interest
    always_comb begin
        push_item.value     = s_rx_value;
        push_item.is_ack    = (s_rx_value == ack_char_reg);
        push_item.is_err    = (s_rx_value == error_char_reg);
        push_item.is_fstart = (s_rx_value == fixed_start_reg);
        push_item.is_vstart = (s_rx_value == variable_start_reg);
        push_item.is_fstop  = (s_rx_value == fixed_stop_reg);
        push_item.is_vstop  = (s_rx_value == variable_stop_reg);
    end

endmodule

### rtl/ft12_queue.sv
// Short queue of classified bytes between front and back.
module ft12_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ft12_pkg::item_t        push_item,
    input  logic                   pop,
    output ft12_pkg::item_t        head_item,
    output ft12_pkg::queue_stat_t  q_stat
);

    ft12_pkg::item_t                  mem [ft12_pkg::QUEUE_DEPTH];
    logic [ft12_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [ft12_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [ft12_pkg::QUEUE_CW-1:0]    count_reg;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == ft12_pkg::QUEUE_AW'(ft12_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ft12_pkg::QUEUE_AW'(ft12_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head_item        = mem[rd_ptr_reg];
    assign q_stat.full      = (count_reg == ft12_pkg::QUEUE_CW'(ft12_pkg::QUEUE_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);

endmodule

### rtl/ft12_back.sv
// Back end: frame state machine, body sum and the result register.
module ft12_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ft12_pkg::queue_stat_t         q_stat,
    input  ft12_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ft12_pkg::result_t             m_result
);

    ft12_pkg::phase_t             phase_reg, phase_next;
    logic                         is_variable_reg, is_variable_next;
    logic [ft12_pkg::BYTE_W-1:0]  first_length_reg, first_length_next;
    logic [ft12_pkg::BYTE_W-1:0]  body_remaining_reg, body_remaining_next;
    logic [ft12_pkg::BYTE_W-1:0]  running_sum_reg, running_sum_next;
    logic [ft12_pkg::BYTE_W-1:0]  held_ctrl_reg, held_ctrl_next;
    logic [ft12_pkg::BYTE_W-1:0]  held_address_reg, held_address_next;
    logic [ft12_pkg::BYTE_W-1:0]  held_command_reg, held_command_next;
    logic [ft12_pkg::BYTE_W-1:0]  payload_count_reg, payload_count_next;
    logic                         sum_matched_reg, sum_matched_next;
    logic                         m_valid_reg, m_valid_next;
    ft12_pkg::result_t            result_reg;
    ft12_pkg::result_t            res;
    logic                         has_res;
    logic [ft12_pkg::BYTE_W-1:0]  b;
    logic [ft12_pkg::BYTE_W-1:0]  rem_dec;
    logic [ft12_pkg::BYTE_W-1:0]  sum_add;
    logic                         stop_ok;
    logic                         len_bad;
    logic                         len_short;

    // Take the next byte when the result register is free or draining
    assign pop = q_stat.not_empty && (!m_valid_reg || m_ready);

    assign b         = head_item.value;
    assign rem_dec   = (body_remaining_reg != '0) ? body_remaining_reg - 1'b1 : '0;
    assign sum_add   = running_sum_reg + b;
    assign stop_ok   = is_variable_reg ? head_item.is_vstop : head_item.is_fstop;
    assign len_bad   = (b != first_length_reg);
    assign len_short = (b < ft12_pkg::BYTE_W'(ft12_pkg::MIN_VAR_LEN));

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            ft12_pkg::PH_HUNT: begin
                if (head_item.is_ack || head_item.is_err) begin
                    phase_next = ft12_pkg::PH_HUNT;
                end else if (head_item.is_fstart) begin
                    phase_next = ft12_pkg::PH_CTRL;
                end else if (head_item.is_vstart) begin
                    phase_next = ft12_pkg::PH_LEN1;
                end else begin
                    phase_next = ft12_pkg::PH_HUNT;
                end
            end
            ft12_pkg::PH_LEN1: phase_next = ft12_pkg::PH_LEN2;
            ft12_pkg::PH_LEN2: begin
                phase_next = (len_bad || len_short) ? ft12_pkg::PH_HUNT : ft12_pkg::PH_RSTART;
            end
            ft12_pkg::PH_RSTART: begin
                phase_next = head_item.is_vstart ? ft12_pkg::PH_CTRL : ft12_pkg::PH_HUNT;
            end
            ft12_pkg::PH_CTRL: phase_next = ft12_pkg::PH_ADDR;
            ft12_pkg::PH_ADDR: phase_next = ft12_pkg::PH_CMD;
            ft12_pkg::PH_CMD: begin
                phase_next = (rem_dec == '0) ? ft12_pkg::PH_SUM : ft12_pkg::PH_DATA;
            end
            ft12_pkg::PH_DATA: begin
                phase_next = (rem_dec == '0) ? ft12_pkg::PH_SUM : ft12_pkg::PH_DATA;
            end
            ft12_pkg::PH_SUM:  phase_next = ft12_pkg::PH_STOP;
            ft12_pkg::PH_STOP: phase_next = ft12_pkg::PH_HUNT;
            default:           phase_next = ft12_pkg::PH_HUNT;
        endcase
    end

    // Frame state updates and the result for this byte
    always_comb begin
        is_variable_next    = is_variable_reg;
        first_length_next   = first_length_reg;
        body_remaining_next = body_remaining_reg;
        running_sum_next    = running_sum_reg;
        held_ctrl_next      = held_ctrl_reg;
        held_address_next   = held_address_reg;
        held_command_next   = held_command_reg;
        payload_count_next  = payload_count_reg;
        sum_matched_next    = sum_matched_reg;
        res                 = '0;
        has_res             = 1'b0;
        case (phase_reg)
            ft12_pkg::PH_HUNT: begin
                has_res  = 1'b1;
                res.last = 1'b1;
                if (head_item.is_ack) begin
                    res.kind = ft12_pkg::KIND_ACK;
                end else if (head_item.is_err) begin
                    res.kind = ft12_pkg::KIND_ERR_CHAR;
                end else if (head_item.is_fstart) begin
                    has_res             = 1'b0;
                    res                 = '0;
                    is_variable_next    = 1'b0;
                    body_remaining_next = ft12_pkg::BYTE_W'(ft12_pkg::FIXED_BODY_LEN);
                    running_sum_next    = '0;
                end else if (head_item.is_vstart) begin
                    has_res          = 1'b0;
                    res              = '0;
                    is_variable_next = 1'b1;
                end else begin
                    res.kind       = ft12_pkg::KIND_FRAME_ERR;
                    res.error_code = ft12_pkg::ERR_NO_START;
                end
            end
            ft12_pkg::PH_LEN1: first_length_next = b;
            ft12_pkg::PH_LEN2: begin
                if (len_bad) begin
                    has_res        = 1'b1;
                    res.kind       = ft12_pkg::KIND_FRAME_ERR;
                    res.error_code = ft12_pkg::ERR_LEN_MISMATCH;
                    res.last       = 1'b1;
                end else if (len_short) begin
                    has_res        = 1'b1;
                    res.kind       = ft12_pkg::KIND_FRAME_ERR;
                    res.error_code = ft12_pkg::ERR_TOO_SHORT;
                    res.last       = 1'b1;
                end
            end
            ft12_pkg::PH_RSTART: begin
                if (!head_item.is_vstart) begin
                    has_res        = 1'b1;
                    res.kind       = ft12_pkg::KIND_FRAME_ERR;
                    res.error_code = ft12_pkg::ERR_BAD_RSTART;
                    res.last       = 1'b1;
                end else begin
                    body_remaining_next = first_length_reg;
                    running_sum_next    = '0;
                end
            end
            ft12_pkg::PH_CTRL: begin
                running_sum_next    = sum_add;
                body_remaining_next = rem_dec;
                held_ctrl_next      = b;
            end
            ft12_pkg::PH_ADDR: begin
                running_sum_next    = sum_add;
                body_remaining_next = rem_dec;
                held_address_next   = b;
            end
            ft12_pkg::PH_CMD: begin
                running_sum_next    = sum_add;
                body_remaining_next = rem_dec;
                held_command_next   = b;
                payload_count_next  = '0;
            end
            ft12_pkg::PH_DATA: begin
                running_sum_next    = sum_add;
                body_remaining_next = rem_dec;
                payload_count_next  = payload_count_reg + 1'b1;
                has_res             = 1'b1;
                res.kind            = ft12_pkg::KIND_DATA;
                res.data_value      = b;
            end
            ft12_pkg::PH_SUM: sum_matched_next = (running_sum_reg == b);
            ft12_pkg::PH_STOP: begin
                has_res  = 1'b1;
                res.last = 1'b1;
                if (!stop_ok) begin
                    res.kind       = ft12_pkg::KIND_FRAME_ERR;
                    res.error_code = ft12_pkg::ERR_NO_STOP;
                end else begin
                    res.kind          = ft12_pkg::KIND_DONE;
                    res.ctrl_value    = held_ctrl_reg;
                    res.address_value = held_address_reg;
                    res.command_value = held_command_reg;
                    res.data_count    = payload_count_reg;
                    res.checksum_ok   = sum_matched_reg;
                end
            end
            default: ;
        endcase
    end

    // Result register valid
    always_comb begin
        if (pop) begin
            m_valid_next = has_res;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= ft12_pkg::PH_HUNT;
            is_variable_reg     <= 1'b0;
            first_length_reg    <= '0;
            body_remaining_reg  <= '0;
            running_sum_reg     <= '0;
            held_ctrl_reg       <= '0;
            held_address_reg    <= '0;
            held_command_reg    <= '0;
            payload_count_reg   <= '0;
            sum_matched_reg     <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg          <= phase_next;
                is_variable_reg    <= is_variable_next;
                first_length_reg   <= first_length_next;
                body_remaining_reg <= body_remaining_next;
                running_sum_reg    <= running_sum_next;
                held_ctrl_reg      <= held_ctrl_next;
                held_address_reg   <= held_address_next;
                held_command_reg   <= held_command_next;
                payload_count_reg  <= payload_count_next;
                sum_matched_reg    <= sum_matched_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop && has_res) begin
            result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

### rtl/ft12_frame_parser.sv
// Top level of the FT1.2 receive frame parser.
//
// Usage: received link bytes enter on the s_ channel (s_valid, s_ready,
// s_rx_value), one byte per transfer. Parsed results leave on the m_
// channel: a data byte for each payload byte, a frame-done item with
// control, address, command, payload count and checksum flag, an ack or
// error character item, or a frame error with its code. Bytes that only
// advance the frame (start, lengths, header, sum) give no result.
// Configuration (start, stop, ack and error characters) is written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write it only while no
// byte is in flight, as the block itself does not enforce this.
// A byte is first written into the queue; the back end then pops it and
// registers its result in the output register.
// Throughput: one byte per cycle while the receiver takes results; the
// back end's state update and 8-bit body sum keep pace with each byte.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result, returns to hunting and restores the default characters.
// When the receiver stalls, the result holds in the output register, the
// two-entry queue keeps taking bytes until full, then s_ready falls.
module ft12_frame_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ft12_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ft12_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ft12_pkg::BYTE_W-1:0]        s_rx_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ft12_pkg::KIND_W-1:0]        m_kind,
    output logic [ft12_pkg::BYTE_W-1:0]        m_data_value,
    output logic [ft12_pkg::BYTE_W-1:0]        m_ctrl_value,
    output logic [ft12_pkg::BYTE_W-1:0]        m_address_value,
    output logic [ft12_pkg::BYTE_W-1:0]        m_command_value,
    output logic [ft12_pkg::BYTE_W-1:0]        m_data_count,
    output logic                               m_checksum_ok,
    output logic [ft12_pkg::ERR_W-1:0]         m_error_code,
    output logic                               m_last
);

    ft12_pkg::queue_stat_t q_stat;
    ft12_pkg::item_t       push_item;
    ft12_pkg::item_t       head_item;
    ft12_pkg::result_t     result;
    logic                  push;
    logic                  pop;

    ft12_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_value (s_rx_value),
        .q_stat     (q_stat),
        .push       (push),
        .push_item  (push_item)
    );

    ft12_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    ft12_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    // Result fields out to ports
    assign m_kind          = result.kind;
    assign m_data_value    = result.data_value;
    assign m_ctrl_value    = result.ctrl_value;
    assign m_address_value = result.address_value;
    assign m_command_value = result.command_value;
    assign m_data_count    = result.data_count;
    assign m_checksum_ok   = result.checksum_ok;
    assign m_error_code    = result.error_code;
    assign m_last          = result.last;

endmodule

### rtl/ft12_checker.sv
// Port-level checks for the FT1.2 frame parser, bound to the top level.
module ft12_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [ft12_pkg::KIND_W-1:0]        m_kind,
    input logic [ft12_pkg::BYTE_W-1:0]        m_data_value,
    input logic [ft12_pkg::ERR_W-1:0]         m_error_code,
    input logic                               m_last
);

    // Only data bytes leave last low
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != ft12_pkg::KIND_DATA)))
        else $error("last does not follow kind");

    // Error code only on frame errors, and always set there
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == ft12_pkg::KIND_FRAME_ERR) == (m_error_code != ft12_pkg::ERR_NONE)))
        else $error("error code inconsistent with kind");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_data_value)))
        else $error("stalled result changed");

endmodule

bind ft12_frame_parser ft12_checker u_ft12_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_data_value (m_data_value),
    .m_error_code (m_error_code),
    .m_last       (m_last)
);

### tb/ft12_frame_parser_tb.sv
// Self-checking testbench for the FT1.2 receive frame parser.
module ft12_frame_parser_tb;
    import ft12_pkg::*;

    // Scoreboard: tracks the deframing state and queues the results each byte should cause
    class ft12_scoreboard;
        bit [7:0] regs [6];
        phase_t   ph;
        bit       in_var;
        bit [7:0] len1;
        bit [7:0] body_left;
        bit [7:0] body_sum;
        bit [7:0] ctrl_b;
        bit [7:0] addr_b;
        bit [7:0] cmd_b;
        bit [7:0] payload_n;
        bit       sum_ok;
        result_t  results_due[$];
        int       fail_count;

        function new();
            regs = '{8'd16, 8'd104, 8'd22, 8'd22, 8'd229, 8'd162};
            ph = PH_HUNT;
        endfunction

        function void set_reg(cfg_reg_t idx, bit [7:0] val);
            regs[idx] = val;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void body_byte(bit [7:0] b);
            body_sum = body_sum + b;
            if (body_left != 0)
                body_left = body_left - 1;
        endfunction

        // One accepted byte: advance the frame state, queue any result
        function void note_rx_byte(bit [7:0] b);
            result_t r;
            bit      emit;
            r = '0;
            emit = 1'b0;
            case (ph)
                PH_HUNT: begin
                    if (b == regs[REG_ACK_CHAR]) begin
                        r.kind = KIND_ACK;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else if (b == regs[REG_ERROR_CHAR]) begin
                        r.kind = KIND_ERR_CHAR;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else if (b == regs[REG_FIXED_START]) begin
                        in_var = 1'b0;
                        body_left = FIXED_BODY_LEN;
                        body_sum = '0;
                        ph = PH_CTRL;
                    end else if (b == regs[REG_VARIABLE_START]) begin
                        in_var = 1'b1;
                        ph = PH_LEN1;
                    end else begin
                        r.kind = KIND_FRAME_ERR;
                        r.error_code = ERR_NO_START;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end
                end
                PH_LEN1: begin
                    len1 = b;
                    ph = PH_LEN2;
                end
                PH_LEN2: begin
                    if (b != len1) begin
                        r.kind = KIND_FRAME_ERR;
                        r.error_code = ERR_LEN_MISMATCH;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else if (b < MIN_VAR_LEN) begin
                        r.kind = KIND_FRAME_ERR;
                        r.error_code = ERR_TOO_SHORT;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else begin
                        ph = PH_RSTART;
                    end
                end
                PH_RSTART: begin
                    if (b != regs[REG_VARIABLE_START]) begin
                        r.kind = KIND_FRAME_ERR;
                        r.error_code = ERR_BAD_RSTART;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else begin
                        body_left = len1;
                        body_sum = '0;
                        ph = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    body_byte(b);
                    ctrl_b = b;
                    ph = PH_ADDR;
                end
                PH_ADDR: begin
                    body_byte(b);
                    addr_b = b;
                    ph = PH_CMD;
                end
                PH_CMD: begin
                    body_byte(b);
                    cmd_b = b;
                    payload_n = '0;
                    ph = (body_left == 0) ? PH_SUM : PH_DATA;
                end
                PH_DATA: begin
                    body_byte(b);
                    payload_n = payload_n + 1;
                    if (body_left == 0)
                        ph = PH_SUM;
                    r.kind = KIND_DATA;
                    r.data_value = b;
                    emit = 1'b1;
                end
                PH_SUM: begin
                    sum_ok = (body_sum == b);
                    ph = PH_STOP;
                end
                PH_STOP: begin
                    if (b != (in_var ? regs[REG_VARIABLE_STOP] : regs[REG_FIXED_STOP])) begin
                        r.kind = KIND_FRAME_ERR;
                        r.error_code = ERR_NO_STOP;
                    end else begin
                        r.kind = KIND_DONE;
                        r.ctrl_value = ctrl_b;
                        r.address_value = addr_b;
                        r.command_value = cmd_b;
                        r.data_count = payload_n;
                        r.checksum_ok = sum_ok;
                    end
                    r.last = 1'b1;
                    emit = 1'b1;
                end
                default: ph = PH_HUNT;
            endcase
            // every terminating result goes back to hunting
            if (r.last)
                ph = PH_HUNT;
            if (emit)
                results_due.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0) begin
                $error("result transfer with no result due (kind %0d)", got.kind);
                fail_count++;
                return;
            end
            want = results_due.pop_front();
            check_field("kind", {5'b0, want.kind}, {5'b0, got.kind});
            check_field("data_value", want.data_value, got.data_value);
            check_field("ctrl_value", want.ctrl_value, got.ctrl_value);
            check_field("address_value", want.address_value, got.address_value);
            check_field("command_value", want.command_value, got.command_value);
            check_field("data_count", want.data_count, got.data_count);
            check_field("checksum_ok", {7'b0, want.checksum_ok}, {7'b0, got.checksum_ok});
            check_field("error_code", {5'b0, want.error_code}, {5'b0, got.error_code});
            check_field("last", {7'b0, want.last}, {7'b0, got.last});
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [KIND_W-1:0]      m_kind;
    logic [BYTE_W-1:0]      m_data_value;
    logic [BYTE_W-1:0]      m_ctrl_value;
    logic [BYTE_W-1:0]      m_address_value;
    logic [BYTE_W-1:0]      m_command_value;
    logic [BYTE_W-1:0]      m_data_count;
    logic                   m_checksum_ok;
    logic [ERR_W-1:0]       m_error_code;
    logic                   m_last;

    ft12_scoreboard sb;
    bit [7:0]       link_bytes[$];
    bit [7:0]       cfg_now [6] = '{8'd16, 8'd104, 8'd22, 8'd22, 8'd229, 8'd162};
    int unsigned    items_sent;
    int unsigned    burst_left;
    int unsigned    seg_left;
    int unsigned    rx_mode;
    bit [7:0]       pat_cnt;

    ft12_frame_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_value      (s_rx_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_value    (m_data_value),
        .m_ctrl_value    (m_ctrl_value),
        .m_address_value (m_address_value),
        .m_command_value (m_command_value),
        .m_data_count    (m_data_count),
        .m_checksum_ok   (m_checksum_ok),
        .m_error_code    (m_error_code),
        .m_last          (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Monitor both channels at each edge
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_rx_byte(s_rx_value);
            if (m_valid && m_ready) begin
                got.kind = kind_t'(m_kind);
                got.data_value = m_data_value;
                got.ctrl_value = m_ctrl_value;
                got.address_value = m_address_value;
                got.command_value = m_command_value;
                got.data_count = m_data_count;
                got.checksum_ok = m_checksum_ok;
                got.error_code = err_code_t'(m_error_code);
                got.last = m_last;
                sb.check_result(got);
            end
        end
    end

    // Receiver: switches between always-ready, random, sparse and square-wave stalls
    always @(posedge aclk) begin
        if (seg_left == 0) begin
            seg_left = $urandom_range(16, 128);
            rx_mode = $urandom_range(0, 3);
        end else begin
            seg_left--;
        end
        pat_cnt++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= pat_cnt[3];
        endcase
    end

    function automatic bit [7:0] nonzero_flip();
        return $urandom_range(1, 255);
    endfunction

    // Queue a frame; fill below zero gives a random body
    function automatic void add_frame(bit is_var, bit [7:0] body_len, int fill,
                                      bit good_sum, bit good_stop);
        bit [7:0] sum;
        bit [7:0] v;
        bit [7:0] stop;
        sum = '0;
        if (is_var) begin
            link_bytes.push_back(cfg_now[REG_VARIABLE_START]);
            link_bytes.push_back(body_len);
            link_bytes.push_back(body_len);
            link_bytes.push_back(cfg_now[REG_VARIABLE_START]);
            stop = cfg_now[REG_VARIABLE_STOP];
        end else begin
            link_bytes.push_back(cfg_now[REG_FIXED_START]);
            body_len = FIXED_BODY_LEN;
            stop = cfg_now[REG_FIXED_STOP];
        end
        for (int i = 0; i < body_len; i++) begin
            v = (fill < 0) ? 8'($urandom) : 8'(fill);
            link_bytes.push_back(v);
            sum = sum + v;
        end
        link_bytes.push_back(good_sum ? sum : sum ^ nonzero_flip());
        link_bytes.push_back(good_stop ? stop : stop ^ nonzero_flip());
    endfunction

    // Variable frame header broken in the way the code names
    function automatic void add_bad_header(err_code_t code);
        bit [7:0] len;
        link_bytes.push_back(cfg_now[REG_VARIABLE_START]);
        case (code)
            ERR_LEN_MISMATCH: begin
                len = $urandom;
                link_bytes.push_back(len);
                link_bytes.push_back(len ^ nonzero_flip());
            end
            ERR_TOO_SHORT: begin
                len = $urandom_range(0, MIN_VAR_LEN - 1);
                link_bytes.push_back(len);
                link_bytes.push_back(len);
            end
            default: begin
                len = $urandom_range(MIN_VAR_LEN, 255);
                link_bytes.push_back(len);
                link_bytes.push_back(len);
                link_bytes.push_back(cfg_now[REG_VARIABLE_START] ^ nonzero_flip());
            end
        endcase
    endfunction

    // One byte transfer, with a random gap at the start of each burst
    task automatic send_byte(bit [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_rx_value <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_queued();
        foreach (link_bytes[i])
            send_byte(link_bytes[i]);
        link_bytes.delete();
    endtask

    // Drain: all results in, then let bytes that cause no result clear the pipeline
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_setting(bit [7:0] vals [6]);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(cfg_reg_t'(i), vals[i]);
            cfg_now[i] = vals[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        bit [7:0]    setting_tbl [6][6];
        bit [7:0]    row [6];
        int unsigned items_goal;
        int unsigned pick;
        bit [7:0]    vlen;
        err_code_t   bad_code;

        sb = new();
        // fixed_start, variable_start, fixed_stop, variable_stop, ack, error
        setting_tbl = '{
            '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h80},
            '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE},
            '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
            '{8'h68, 8'h68, 8'h16, 8'h16, 8'hA2, 8'hA2},
            '{8'hE5, 8'h68, 8'h16, 8'h16, 8'hE5, 8'h68},
            '{8'd16, 8'd104, 8'd22, 8'd22, 8'd229, 8'd162}
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass on reset values: single characters, unknown byte,
        // sum wraparound with bad checksum, no-payload frame with stop missing,
        // and each broken variable header
        link_bytes.push_back(cfg_now[REG_ACK_CHAR]);
        link_bytes.push_back(cfg_now[REG_ERROR_CHAR]);
        link_bytes.push_back(8'h00);
        add_frame(1'b0, FIXED_BODY_LEN, 255, 1'b0, 1'b1);
        add_frame(1'b1, MIN_VAR_LEN, -1, 1'b1, 1'b0);
        add_bad_header(ERR_LEN_MISMATCH);
        add_bad_header(ERR_TOO_SHORT);
        add_bad_header(ERR_BAD_RSTART);
        send_queued();
        items_goal = items_sent;

        // Random traffic under each register setting; the third row is random
        for (int s = 0; s < 6; s++) begin
            s_valid <= 1'b0;
            wait_idle();
            row = setting_tbl[s];
            if (s == 2) begin
                foreach (row[i])
                    row[i] = $urandom;
            end
            apply_setting(row);
            items_goal += 254;
            while (items_sent < items_goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    add_frame(1'b0, FIXED_BODY_LEN, -1, $urandom_range(0, 99) < 85,
                              $urandom_range(0, 99) < 90);
                end else if (pick < 65) begin
                    vlen = ($urandom_range(0, 99) < 3) ? $urandom_range(200, 255)
                                                       : $urandom_range(MIN_VAR_LEN, 16);
                    add_frame(1'b1, vlen, -1, $urandom_range(0, 99) < 85,
                              $urandom_range(0, 99) < 90);
                end else if (pick < 73) begin
                    link_bytes.push_back(cfg_now[REG_ACK_CHAR]);
                end else if (pick < 78) begin
                    link_bytes.push_back(cfg_now[REG_ERROR_CHAR]);
                end else if (pick < 90) begin
                    case ($urandom_range(0, 2))
                        0: bad_code = ERR_LEN_MISMATCH;
                        1: bad_code = ERR_TOO_SHORT;
                        default: bad_code = ERR_BAD_RSTART;
                    endcase
                    add_bad_header(bad_code);
                end else begin
                    repeat ($urandom_range(1, 3))
                        link_bytes.push_back($urandom);
                end
                send_queued();
            end
        end

        s_valid <= 1'b0;
        wait_idle();
        if (sb.fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
